FILE: design/char_lcd_buffer_refresh_macros.svh
// assertion macros for the character lcd buffer refresh block
`ifndef CHAR_LCD_BUFFER_REFRESH_MACROS_SVH
`define CHAR_LCD_BUFFER_REFRESH_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every rising edge outside reset
`define CLB_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication, checked at every rising edge outside reset
`define CLB_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define CLB_ASSERT_IMP(name, ante, cons)
`define CLB_ASSERT_NXT(name, ante, cons)

`endif

`endif

FILE: design/clb_pkg.sv
// types, constants and the transfer builder of the character lcd buffer refresh block
package clb_pkg;

  // commands carried by an input transaction
  typedef enum logic [1:0] {
    CMD_PLACE   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_REFRESH = 2'd3
  } cmd_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ROWS      = 2'd0,
    REG_COLS      = 2'd1,
    REG_BACKLIGHT = 2'd2,
    REG_BUS_ADDR  = 2'd3
  } reg_idx_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_PLACE,
    S_APPEND,
    S_CLEAR,
    S_RF_ADDR,
    S_RF_READ,
    S_RF_DATA
  } state_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [6:0] target_address;
    logic [7:0] byte_hi_strobe;
    logic [7:0] byte_hi_release;
    logic [7:0] byte_lo_strobe;
    logic [7:0] byte_lo_release;
    logic       last_transfer;
  } out_item_t;

  // expander bit layout and panel commands
  localparam logic [7:0] EN_BIT      = 8'h04;
  localparam logic [7:0] RS_BIT      = 8'h01;
  localparam logic [7:0] BL_BIT      = 8'h08;
  localparam logic [7:0] NIB_MASK    = 8'hF0;
  localparam logic [7:0] SET_ADDR    = 8'h80;
  localparam logic [7:0] ROW0_OFFSET = 8'h00;
  localparam logic [7:0] ROW1_OFFSET = 8'h40;
  localparam logic [7:0] SPACE_CHAR  = 8'h20;

  // register reset values
  localparam logic [1:0] RST_ROWS     = 2'd2;
  localparam logic [4:0] RST_COLS     = 5'd16;
  localparam logic       RST_BL       = 1'b1;
  localparam logic [6:0] RST_BUS_ADDR = 7'd39;

  // build the four expander bytes of one transfer
  function automatic out_item_t make_xfer(input logic [7:0] v, input logic is_data,
                                          input logic last, input logic bl,
                                          input logic [6:0] addr);
    logic [7:0] ctl;
    logic [7:0] hi;
    logic [7:0] lo;
    out_item_t  x;
    ctl = (bl ? BL_BIT : 8'h00) | (is_data ? RS_BIT : 8'h00);
    hi  = (v & NIB_MASK) | ctl;
    lo  = {v[3:0], 4'h0} | ctl;
    x.target_address  = addr;
    x.byte_hi_strobe  = hi | EN_BIT;
    x.byte_hi_release = hi;
    x.byte_lo_strobe  = lo | EN_BIT;
    x.byte_lo_release = lo;
    x.last_transfer   = last;
    return x;
  endfunction

endpackage

FILE: design/char_lcd_buffer_refresh.sv
// character lcd screen store with cursor and expander refresh sequencer
// place: accept, column remainder on the shared unit, then the write
// append and clear: accept, then the update; no item is accepted meanwhile
// refresh: per row a set-address transfer, then per column a read state and a data
// transfer, the read state covering the registered read of the store ram
// synchronous active-low reset: store reads as spaces, cursor zero, registers to defaults
`include "char_lcd_buffer_refresh_macros.svh"

module char_lcd_buffer_refresh #(
  parameter int MAX_ROWS = 2,
  parameter int MAX_COLS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  clb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output clb_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import clb_pkg::*;

  localparam int         DEPTH      = MAX_ROWS * MAX_COLS;
  localparam int         IDX_W      = $clog2(DEPTH);
  localparam logic [1:0] MAX_ROWS_V = 2'(MAX_ROWS);
  localparam logic [4:0] MAX_COLS_V = 5'(MAX_COLS);
  localparam logic [2:0] STEP_LAST  = 3'd7;

  // configuration registers
  logic [1:0] rows_r;
  logic [4:0] cols_r;
  logic       bl_r;
  logic [6:0] bus_addr_r;
  logic       cfg_wr;

  // sequencer and datapath state
  state_t             state_r, state_nxt;
  logic               row_bit_r, row_bit_nxt;
  logic [7:0]         col_sh_r, col_sh_nxt;
  logic [7:0]         ch_r, ch_nxt;
  logic [4:0]         rem_r, rem_nxt;
  logic [2:0]         step_r, step_nxt;
  logic [4:0]         cols_q_r, cols_q_nxt;
  logic               two_rows_q_r, two_rows_q_nxt;
  logic [5:0]         cursor_r, cursor_nxt;
  logic [DEPTH-1:0]   vld_r, vld_nxt;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [4:0]         col_r, col_nxt;
  logic               row_r, row_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic [1:0]         rows_eff;
  logic [4:0]         cols_eff;
  logic [5:0]         size_q;
  logic               in_accept;
  logic               slot_free;
  logic               out_load;
  logic               col_last;
  logic               row_last;
  logic [5:0]         trial;
  logic [7:0]         rd_char;

  // shared add/subtract unit
  logic [6:0]         alu_a;
  logic [6:0]         alu_b;
  logic               alu_sub;
  logic [7:0]         alu_res;

  // store ram ports
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [7:0]         ram_rdata;

  // apb register file
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r     <= RST_ROWS;
      cols_r     <= RST_COLS;
      bl_r       <= RST_BL;
      bus_addr_r <= RST_BUS_ADDR;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_ROWS:      rows_r     <= pwdata[1:0];
        REG_COLS:      cols_r     <= pwdata[4:0];
        REG_BACKLIGHT: bl_r       <= pwdata[0];
        REG_BUS_ADDR:  bus_addr_r <= pwdata[6:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_ROWS:      prdata = {30'd0, rows_r};
      REG_COLS:      prdata = {27'd0, cols_r};
      REG_BACKLIGHT: prdata = {31'd0, bl_r};
      REG_BUS_ADDR:  prdata = {25'd0, bus_addr_r};
    endcase
  end

  // clamp the geometry registers into range
  always_comb begin
    if (rows_r == 2'd0) begin
      rows_eff = 2'd1;
    end else if (rows_r > MAX_ROWS_V) begin
      rows_eff = MAX_ROWS_V;
    end else begin
      rows_eff = rows_r;
    end
    if (cols_r == 5'd0) begin
      cols_eff = 5'd1;
    end else if (cols_r > MAX_COLS_V) begin
      cols_eff = MAX_COLS_V;
    end else begin
      cols_eff = cols_r;
    end
  end

  // handshake and loop terms
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign size_q    = two_rows_q_r ? {cols_q_r, 1'b0} : {1'b0, cols_q_r};
  assign col_last  = (col_r == cols_q_r - 5'd1);
  assign row_last  = two_rows_q_r ? row_r : 1'b1;
  assign trial     = {rem_r, col_sh_r[7]};
  assign rd_char   = rd_vld_r ? ram_rdata : SPACE_CHAR;

  // shared unit: remainder step, place address, append bound check
  always_comb begin
    alu_a   = 7'd0;
    alu_b   = 7'd0;
    alu_sub = 1'b0;
    unique case (state_r)
      S_MOD: begin
        alu_a   = {1'b0, trial};
        alu_b   = {2'b0, cols_q_r};
        alu_sub = 1'b1;
      end
      S_PLACE: begin
        alu_a = {2'b0, rem_r};
        alu_b = row_bit_r ? {2'b0, cols_q_r} : 7'd0;
      end
      S_APPEND: begin
        alu_a   = {1'b0, cursor_r};
        alu_b   = {1'b0, size_q};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = 7'd0;
      end
    endcase
    alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_data.command)
            CMD_PLACE:   state_nxt = S_MOD;
            CMD_APPEND:  state_nxt = S_APPEND;
            CMD_CLEAR:   state_nxt = S_CLEAR;
            CMD_REFRESH: state_nxt = S_RF_ADDR;
          endcase
        end
      end
      S_MOD: begin
        if (step_r == STEP_LAST) state_nxt = S_PLACE;
      end
      S_PLACE, S_APPEND, S_CLEAR: begin
        state_nxt = S_IDLE;
      end
      S_RF_ADDR: begin
        if (slot_free) state_nxt = S_RF_READ;
      end
      S_RF_READ: begin
        state_nxt = S_RF_DATA;
      end
      S_RF_DATA: begin
        if (slot_free) begin
          if (!col_last) begin
            state_nxt = S_RF_READ;
          end else if (row_last) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RF_ADDR;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs per state
  always_comb begin
    row_bit_nxt    = row_bit_r;
    col_sh_nxt     = col_sh_r;
    ch_nxt         = ch_r;
    rem_nxt        = rem_r;
    step_nxt       = step_r;
    cols_q_nxt     = cols_q_r;
    two_rows_q_nxt = two_rows_q_r;
    cursor_nxt     = cursor_r;
    vld_nxt        = vld_r;
    idx_nxt        = idx_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    out_load       = 1'b0;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    unique case (state_r)
      S_IDLE: begin
        // latch the transaction and the geometry it runs with
        if (in_accept) begin
          row_bit_nxt    = (rows_eff == 2'd2) ? in_data.row[0] : 1'b0;
          col_sh_nxt     = in_data.col;
          ch_nxt         = in_data.char_code;
          rem_nxt        = 5'd0;
          step_nxt       = 3'd0;
          cols_q_nxt     = cols_eff;
          two_rows_q_nxt = (rows_eff == 2'd2);
          idx_nxt        = '0;
          row_nxt        = 1'b0;
        end
      end
      S_MOD: begin
        // restoring remainder, one column bit per cycle
        rem_nxt    = alu_res[7] ? trial[4:0] : alu_res[4:0];
        col_sh_nxt = {col_sh_r[6:0], 1'b0};
        step_nxt   = step_r + 3'd1;
      end
      S_PLACE: begin
        ram_we            = 1'b1;
        ram_waddr         = alu_res[IDX_W-1:0];
        vld_nxt[ram_waddr] = 1'b1;
        cursor_nxt        = alu_res[5:0];
      end
      S_APPEND: begin
        // borrow means the cursor is inside the active area
        if (alu_res[7]) begin
          ram_we             = 1'b1;
          ram_waddr          = cursor_r[IDX_W-1:0];
          vld_nxt[ram_waddr] = 1'b1;
          cursor_nxt         = cursor_r + 6'd1;
        end else begin
          cursor_nxt = size_q;
        end
      end
      S_CLEAR: begin
        vld_nxt = '0;
      end
      S_RF_ADDR: begin
        // set-address transfer for the current row
        if (slot_free) begin
          out_load     = 1'b1;
          out_data_nxt = make_xfer(SET_ADDR | (row_r ? ROW1_OFFSET : ROW0_OFFSET),
                                   1'b0, 1'b0, bl_r, bus_addr_r);
          col_nxt      = 5'd0;
        end
      end
      S_RF_READ: begin
        col_nxt = col_r;
      end
      S_RF_DATA: begin
        // one data transfer per column
        if (slot_free) begin
          out_load     = 1'b1;
          out_data_nxt = make_xfer(rd_char, 1'b1, col_last && row_last, bl_r, bus_addr_r);
          idx_nxt      = idx_r + IDX_W'(1);
          col_nxt      = col_r + 5'd1;
          if (col_last) row_nxt = 1'b1;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= 6'd0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    row_bit_r    <= row_bit_nxt;
    col_sh_r     <= col_sh_nxt;
    ch_r         <= ch_nxt;
    rem_r        <= rem_nxt;
    step_r       <= step_nxt;
    cols_q_r     <= cols_q_nxt;
    two_rows_q_r <= two_rows_q_nxt;
    idx_r        <= idx_nxt;
    col_r        <= col_nxt;
    row_r        <= row_nxt;
    rd_vld_r     <= vld_r[idx_r];
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // screen store
  clb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ch_r),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // checks on the sequencer
  `CLB_ASSERT_IMP(a_rem_in_range, (state_r == S_MOD || state_r == S_PLACE), (rem_r < cols_q_r))
  `CLB_ASSERT_NXT(a_accept_starts, in_accept, (state_r != S_IDLE))
  `CLB_ASSERT_IMP(a_write_states, ram_we, (state_r == S_PLACE || state_r == S_APPEND))
  `CLB_ASSERT_IMP(a_col_in_range, (state_r == S_RF_DATA), (col_r <= cols_q_r - 5'd1))
  `CLB_ASSERT_IMP(a_out_from_refresh, $rose(out_valid_r),
                  ($past(state_r) == S_RF_ADDR || $past(state_r) == S_RF_DATA))

endmodule

FILE: design/clb_ram.sv
// generic single-write, single-read ram with registered read data
module clb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sim/tb.sv
// self-checking testbench for the character lcd buffer refresh block
`timescale 1ns / 100ps

module tb;
  import clb_pkg::*;

  localparam int MAX_ROWS    = 2;
  localparam int MAX_COLS    = 20;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 18;
  localparam int SETTLE      = 32;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_PHASE  = 6;
  localparam int CYCLE_LIMIT = 1000000;

  // register settings per phase, extremes and out-of-range values included
  localparam logic [1:0] PH_ROWS [NUM_PHASES] = '{2'd1, 2'd0, 2'd3, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1};
  localparam logic [4:0] PH_COLS [NUM_PHASES] = '{5'd1, 5'd0, 5'd31, 5'd8, 5'd20, 5'd1, 5'd20,
                                                  5'd13};
  localparam logic       PH_BL   [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
  localparam logic [6:0] PH_ADDR [NUM_PHASES] = '{7'd0, 7'd85, 7'd42, 7'd39, 7'd100, 7'd3, 7'd127,
                                                  7'd64};

  // set-address transfer of row 0 under reset settings
  localparam out_item_t XFER_ROW0_RESET = '{target_address: 7'd39, byte_hi_strobe: 8'h8C,
                                            byte_hi_release: 8'h88, byte_lo_strobe: 8'h0C,
                                            byte_lo_release: 8'h08, last_transfer: 1'b0};

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t first;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // shadow copy of the screen, cursor and registers
  logic [7:0]  screen [STORE_DEPTH];
  logic [5:0]  cursor;
  logic [1:0]  cfg_rows;
  logic [4:0]  cfg_cols;
  logic        cfg_bl;
  logic [6:0]  cfg_addr;

  out_item_t   xfer_q [$];
  dir_row_t    dir_tab [$];
  out_item_t   want;
  int          mismatches = 0;
  int          in_idle_pct = 24;
  int          out_stall_pct = 87;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_cnt;
  int          cycle_cnt = 0;

  char_lcd_buffer_refresh u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      mismatches++;
    end
  endtask

  function automatic int eff_rows();
    if (cfg_rows < 1) return 1;
    if (cfg_rows > MAX_ROWS) return MAX_ROWS;
    return int'(cfg_rows);
  endfunction

  function automatic int eff_cols();
    if (cfg_cols < 1) return 1;
    if (cfg_cols > MAX_COLS) return MAX_COLS;
    return int'(cfg_cols);
  endfunction

  // one expander transfer: four nibble bytes with backlight, rs and en
  function automatic out_item_t lcd_xfer(input logic [7:0] v, input logic is_data,
                                         input logic last);
    logic [7:0] ctl;
    out_item_t  x;
    ctl = (cfg_bl ? BL_BIT : 8'h00) | (is_data ? RS_BIT : 8'h00);
    x.target_address  = cfg_addr;
    x.byte_hi_release = (v & NIB_MASK) | ctl;
    x.byte_hi_strobe  = x.byte_hi_release | EN_BIT;
    x.byte_lo_release = {v[3:0], 4'h0} | ctl;
    x.byte_lo_strobe  = x.byte_lo_release | EN_BIT;
    x.last_transfer   = last;
    return x;
  endfunction

  task automatic screen_reset();
    foreach (screen[i]) screen[i] = SPACE_CHAR;
    cursor   = '0;
    cfg_rows = RST_ROWS;
    cfg_cols = RST_COLS;
    cfg_bl   = RST_BL;
    cfg_addr = RST_BUS_ADDR;
  endtask

  // update the screen copy and queue the transfers an accepted command causes
  task automatic predict_screen(input in_item_t it, input logic typed, input out_item_t first);
    int rows;
    int cols;
    int size;
    int idx;
    logic [7:0] addr_cmd;
    rows = eff_rows();
    cols = eff_cols();
    size = rows * cols;
    case (it.command)
      CMD_PLACE: begin
        idx = (int'(it.row) % rows) * cols + (int'(it.col) % cols);
        screen[idx] = it.char_code;
        cursor = idx[5:0];
      end
      CMD_APPEND: begin
        if (int'(cursor) < size) begin
          screen[cursor] = it.char_code;
          cursor = cursor + 6'd1;
        end else begin
          cursor = size[5:0];
        end
      end
      CMD_CLEAR: begin
        foreach (screen[i]) screen[i] = SPACE_CHAR;
      end
      default: begin
        for (int r = 0; r < rows; r++) begin
          addr_cmd = SET_ADDR | ((r != 0) ? ROW1_OFFSET : ROW0_OFFSET);
          if (r == 0 && typed) xfer_q.push_back(first);
          else xfer_q.push_back(lcd_xfer(addr_cmd, 1'b0, 1'b0));
          for (int c = 0; c < cols; c++)
            xfer_q.push_back(lcd_xfer(screen[r * cols + c], 1'b1,
                                      (r == rows - 1) && (c == cols - 1)));
        end
      end
    endcase
  endtask

  // offer one command, starting and ending at a falling edge
  task automatic send_cmd(input in_item_t it, input logic typed, input out_item_t first);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_screen(it, typed, first);
    @(negedge clk);
  endtask

  // register write then read-back, both over the apb port
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] stored;
    case (idx)
      REG_ROWS:      begin cfg_rows = val[1:0]; stored = {30'd0, cfg_rows}; end
      REG_COLS:      begin cfg_cols = val[4:0]; stored = {27'd0, cfg_cols}; end
      REG_BACKLIGHT: begin cfg_bl   = val[0];   stored = {31'd0, cfg_bl};   end
      default:       begin cfg_addr = val[6:0]; stored = {25'd0, cfg_addr}; end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pwdata  <= $urandom;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("prdata", stored, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    // return to idle so the next transfer starts at a later edge
    @(negedge clk);
  endtask

  // wait for all transfers, then let a pending command finish
  task automatic drain_and_settle();
    while (xfer_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic in_item_t rand_cmd();
    in_item_t it;
    int pick;
    pick = $urandom_range(99);
    if (pick < 30)      it.command = CMD_PLACE;
    else if (pick < 65) it.command = CMD_APPEND;
    else if (pick < 73) it.command = CMD_CLEAR;
    else                it.command = CMD_REFRESH;
    if ($urandom_range(1) != 0) begin
      it.row = 8'($urandom_range(255));
      it.col = 8'($urandom_range(255));
    end else begin
      it.row = 8'($urandom_range(3));
      it.col = 8'($urandom_range(24));
    end
    it.char_code = 8'($urandom_range(255));
    return it;
  endfunction

  task automatic add_row(input cmd_t cmd, input logic [7:0] row, input logic [7:0] col,
                         input logic [7:0] ch, input logic typed);
    dir_row_t d;
    d.item.command   = cmd;
    d.item.row       = row;
    d.item.col       = col;
    d.item.char_code = ch;
    d.typed          = typed;
    d.first          = XFER_ROW0_RESET;
    dir_tab.push_back(d);
  endtask

  // receiver: random stalls, plus one long hold-off
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      out_stall <= 1'b1;
      for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk);
    end
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // compare each result transaction with the oldest expected transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (xfer_q.size() == 0) begin
        $error("result transaction with no transfer expected");
        mismatches++;
      end else begin
        want = xfer_q.pop_front();
        check_field("target_address", 32'(want.target_address),
                    32'(out_data.target_address));
        check_field("byte_hi_strobe", 32'(want.byte_hi_strobe),
                    32'(out_data.byte_hi_strobe));
        check_field("byte_hi_release", 32'(want.byte_hi_release),
                    32'(out_data.byte_hi_release));
        check_field("byte_lo_strobe", 32'(want.byte_lo_strobe),
                    32'(out_data.byte_lo_strobe));
        check_field("byte_lo_release", 32'(want.byte_lo_release),
                    32'(out_data.byte_lo_release));
        check_field("last_transfer", 32'(want.last_transfer),
                    32'(out_data.last_transfer));
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    in_item_t it;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    screen_reset();

    // directed commands under reset settings: 2 rows of 16
    add_row(CMD_REFRESH, 8'h00, 8'h00, 8'h00, 1'b1);
    add_row(CMD_PLACE,   8'h00, 8'h00, 8'hFF, 1'b0);
    add_row(CMD_PLACE,   8'hFF, 8'hFF, 8'h00, 1'b0);   // wraps to the last cell
    add_row(CMD_APPEND,  8'h00, 8'h00, 8'h41, 1'b0);   // fills the last cell
    add_row(CMD_APPEND,  8'h00, 8'h00, 8'h5A, 1'b0);   // past the end, dropped
    add_row(CMD_APPEND,  8'h00, 8'h00, 8'h5B, 1'b0);
    add_row(CMD_PLACE,   8'h00, 8'h0F, 8'h7E, 1'b0);   // end of row 0
    add_row(CMD_APPEND,  8'h00, 8'h00, 8'hA5, 1'b0);   // overwrites the placed cell
    add_row(CMD_APPEND,  8'h00, 8'h00, 8'h3C, 1'b0);   // wraps into row 1
    add_row(CMD_REFRESH, 8'h00, 8'h00, 8'h00, 1'b0);
    add_row(CMD_PLACE,   8'h02, 8'h10, 8'h81, 1'b0);
    add_row(CMD_PLACE,   8'hAA, 8'h55, 8'hC3, 1'b0);
    add_row(CMD_APPEND,  8'h00, 8'h00, 8'h0F, 1'b0);
    add_row(CMD_CLEAR,   8'h00, 8'h00, 8'h00, 1'b0);
    add_row(CMD_REFRESH, 8'h00, 8'h00, 8'h00, 1'b1);
    add_row(CMD_APPEND,  8'h00, 8'h00, 8'hF0, 1'b0);   // cursor kept over clear
    add_row(CMD_REFRESH, 8'h00, 8'h00, 8'h00, 1'b0);

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) send_cmd(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].first);
    in_valid <= 1'b0;

    // random phases, each under new register settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_and_settle();
      reg_write(REG_ROWS,      ($urandom << 2) | 32'(PH_ROWS[p]));
      reg_write(REG_COLS,      ($urandom << 5) | 32'(PH_COLS[p]));
      reg_write(REG_BACKLIGHT, ($urandom << 1) | 32'(PH_BL[p]));
      reg_write(REG_BUS_ADDR,  ($urandom << 7) | 32'(PH_ADDR[p]));
      if (p < 3) begin
        in_idle_pct   = 24;
        out_stall_pct = 87;
      end else if (p < 6) begin
        in_idle_pct   = 87;
        out_stall_pct = 24;
      end else begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
      end
      if (p == HOLD_PHASE) hold_go = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        it = rand_cmd();
        // back-to-back refreshes while the receiver holds off
        if (p == HOLD_PHASE && k < 4) it.command = CMD_REFRESH;
        send_cmd(it, 1'b0, XFER_ROW0_RESET);
      end
      in_valid <= 1'b0;
    end

    drain_and_settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
